/* hdl/smvs_pkg.sv */
// ----------------------------------------------------------------------------
// smvs_pkg
// Shared widths, payload types and controller/datapath signal groups for the
// sample mean, variance and standard deviation unit.
// ----------------------------------------------------------------------------
package smvs_pkg;

	localparam int MAX_SAMPLES = 128;

	localparam int SMP_W  = 24;                          // Q12.12 sample
	localparam int ADDR_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SMP_W + CNT_W;
	localparam int DEV_W  = SMP_W + 1;
	localparam int SQR_W  = 2 * SMP_W;
	localparam int SQS_W  = SQR_W + CNT_W;
	localparam int VAR_W  = 48;
	localparam int SD_W   = 24;
	localparam int OCNT_W = 8;
	localparam int DSTEP_W = $clog2(SQS_W + 1);
	localparam int RSTEP_W = $clog2(SD_W + 1);
	localparam int RREM_W  = SD_W + 1;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    last;
	} smp_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] mean;
		logic [VAR_W-1:0]        variance;
		logic [SD_W-1:0]         std_dev;
		logic [OCNT_W-1:0]       count;
		logic                    overflowed;
	} res_t;

	typedef struct packed {
		logic take;
		logic div_start;
		logic div_var;
		logic mean_load;
		logic pass_start;
		logic var_load;
		logic sqrt_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic pass_done;
		logic sqrt_done;
	} sts_t;

endpackage

/* hdl/sample_mean_variance_stddev_unit.sv */
// ----------------------------------------------------------------------------
// sample_mean_variance_stddev_unit
// Mean, population variance and standard deviation of a set of Q12.12 words.
//
// Input channel smp_valid/smp_stall/smp_word carries one sample per word;
// the word with last set closes the set. Words are taken one per cycle while
// loading, up to 128 are stored, later ones are dropped and flagged.
// After the closing word the input stalls while the unit computes: a 56-step
// shared divider forms the mean, a second pass rereads the N stored samples
// through a three-stage deviation/square pipeline, the same divider forms the
// variance and a 24-step root unit the standard deviation, and the result
// word then appears on res_valid/res_word.
// The result sits in an output register: loading of the next set goes on
// while res_stall holds it; a further result waits until it is taken.
// Reset clears counts, sum, flag and the handshake; the store is not cleared.
// ----------------------------------------------------------------------------
module sample_mean_variance_stddev_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           smp_valid,
	output logic           smp_stall,
	input  smvs_pkg::smp_t smp_word,
	output logic           res_valid,
	input  logic           res_stall,
	output smvs_pkg::res_t res_word
);

	smvs_pkg::cmd_t cmd;
	smvs_pkg::sts_t sts;

	smvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_last  (smp_word.last),
		.res_stall (res_stall),
		.sts       (sts),
		.smp_stall (smp_stall),
		.res_valid (res_valid),
		.cmd       (cmd)
	);

	smvs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.smp_word (smp_word),
		.cmd      (cmd),
		.sts      (sts),
		.res_word (res_word)
	);

endmodule

/* hdl/smvs_div.sv */
// ----------------------------------------------------------------------------
// smvs_div
// Restoring unsigned divider, one quotient bit per cycle. Divides the wide
// accumulator by the sample count; the remainder is discarded.
// ----------------------------------------------------------------------------
module smvs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [smvs_pkg::SQS_W-1:0] dividend,
	input  logic [smvs_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [smvs_pkg::SQS_W-1:0] quotient
);

	logic                       busy_q;
	logic                       done_q;
	logic [smvs_pkg::DSTEP_W-1:0] step_q;
	logic [smvs_pkg::CNT_W-1:0]   rem_q;
	logic [smvs_pkg::SQS_W-1:0]   quo_q;
	logic [smvs_pkg::CNT_W:0]     trial;
	logic [smvs_pkg::CNT_W:0]     diff;
	logic                         fits;

	assign trial = {rem_q, quo_q[smvs_pkg::SQS_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == smvs_pkg::DSTEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= smvs_pkg::DSTEP_W'(smvs_pkg::SQS_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == smvs_pkg::DSTEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract where it fits
			if (fits) begin
				rem_q <= diff[smvs_pkg::CNT_W-1:0];
			end else begin
				rem_q <= trial[smvs_pkg::CNT_W-1:0];
			end
			quo_q <= {quo_q[smvs_pkg::SQS_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hdl/smvs_sqrt.sv */
// ----------------------------------------------------------------------------
// smvs_sqrt
// Digit-by-digit floor square root, one root bit per cycle over a 48-bit
// radicand.
// ----------------------------------------------------------------------------
module smvs_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [smvs_pkg::VAR_W-1:0] radicand,
	output logic                      done,
	output logic [smvs_pkg::SD_W-1:0]  root
);

	logic                         busy_q;
	logic                         done_q;
	logic [smvs_pkg::RSTEP_W-1:0] step_q;
	logic [smvs_pkg::VAR_W-1:0]   rad_q;
	logic [smvs_pkg::RREM_W-1:0]  rem_q;
	logic [smvs_pkg::SD_W-1:0]    root_q;
	logic [smvs_pkg::RREM_W+1:0]  trial;
	logic [smvs_pkg::RREM_W+1:0]  sub;
	logic [smvs_pkg::RREM_W+1:0]  diff;
	logic                         fits;

	assign trial = {rem_q, rad_q[smvs_pkg::VAR_W-1 -: 2]};
	assign sub   = {1'b0, root_q, 2'b01};
	assign diff  = trial - sub;
	assign fits  = (trial >= sub);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == smvs_pkg::RSTEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= smvs_pkg::RSTEP_W'(smvs_pkg::SD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == smvs_pkg::RSTEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			// bring down two radicand bits per step
			rad_q <= {rad_q[smvs_pkg::VAR_W-3:0], 2'b00};
			if (fits) begin
				rem_q <= diff[smvs_pkg::RREM_W-1:0];
			end else begin
				rem_q <= trial[smvs_pkg::RREM_W-1:0];
			end
			root_q <= {root_q[smvs_pkg::SD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* hdl/smvs_datapath.sv */
// ----------------------------------------------------------------------------
// smvs_datapath
// Sample store, running sum, second-pass deviation/square pipeline, shared
// divider, square root unit and result register.
// ----------------------------------------------------------------------------
module smvs_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  smvs_pkg::smp_t smp_word,
	input  smvs_pkg::cmd_t cmd,
	output smvs_pkg::sts_t sts,
	output smvs_pkg::res_t res_word
);

	logic signed [smvs_pkg::SMP_W-1:0] mem [smvs_pkg::MAX_SAMPLES];

	logic [smvs_pkg::CNT_W-1:0]         cnt_q;
	logic signed [smvs_pkg::SUM_W-1:0]  sum_q;
	logic                               drop_q;
	logic signed [smvs_pkg::SMP_W-1:0]  mean_q;
	logic [smvs_pkg::VAR_W-1:0]         var_q;
	logic [smvs_pkg::SQS_W-1:0]         sqs_q;
	smvs_pkg::res_t                     res_q;

	logic [smvs_pkg::ADDR_W-1:0]        rd_idx_q;
	logic                               issue_q;
	logic signed [smvs_pkg::SMP_W-1:0]  rd_data_s1;
	logic                               v_s1, l_s1;
	logic signed [smvs_pkg::DEV_W-1:0]  dev_s2;
	logic                               v_s2, l_s2;
	logic [smvs_pkg::SQR_W-1:0]         sq_s3;
	logic                               v_s3, l_s3;
	logic                               pass_done_q;

	logic                               full;
	logic                               wr_en;
	logic                               rd_last;
	logic [smvs_pkg::SUM_W-1:0]         sum_mag;
	logic [smvs_pkg::SQS_W-1:0]         dividend;
	logic [smvs_pkg::SQS_W-1:0]         quotient;
	logic                               div_done;
	logic [smvs_pkg::SMP_W-1:0]         quo_lo;
	logic signed [2*smvs_pkg::DEV_W-1:0] prod;
	logic [smvs_pkg::SD_W-1:0]          root;
	logic                               sqrt_done;

	assign full    = (cnt_q == smvs_pkg::CNT_W'(smvs_pkg::MAX_SAMPLES));
	assign wr_en   = cmd.take && !full;
	assign rd_last = (rd_idx_q == smvs_pkg::ADDR_W'(cnt_q - 1'b1));

	// divide the magnitude, restore the sign after: truncation toward zero
	assign sum_mag  = sum_q[smvs_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign dividend = cmd.div_var ? sqs_q : smvs_pkg::SQS_W'(sum_mag);
	assign quo_lo   = quotient[smvs_pkg::SMP_W-1:0];
	assign prod     = dev_s2 * dev_s2;

	smvs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quotient)
	);

	smvs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (var_q),
		.done     (sqrt_done),
		.root     (root)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[smvs_pkg::ADDR_W-1:0]] <= smp_word.sample;
		end
		if (issue_q) begin
			rd_data_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sum_q       <= '0;
			drop_q      <= 1'b0;
			issue_q     <= 1'b0;
			rd_idx_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			pass_done_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				cnt_q  <= '0;
				sum_q  <= '0;
				drop_q <= 1'b0;
			end else if (wr_en) begin
				cnt_q <= cnt_q + 1'b1;
				sum_q <= sum_q + smvs_pkg::SUM_W'(smp_word.sample);
			end else if (cmd.take) begin
				// store full: drop the word, keep the flag
				drop_q <= 1'b1;
			end

			if (cmd.pass_start) begin
				issue_q  <= 1'b1;
				rd_idx_q <= '0;
			end else if (issue_q) begin
				if (rd_last) begin
					issue_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			v_s1        <= issue_q;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			pass_done_q <= v_s3 && l_s3;
		end
	end

	always_ff @(posedge clk) begin
		l_s1   <= rd_last;
		l_s2   <= l_s1;
		l_s3   <= l_s2;
		dev_s2 <= smvs_pkg::DEV_W'(rd_data_s1) - smvs_pkg::DEV_W'(mean_q);
		sq_s3  <= prod[smvs_pkg::SQR_W-1:0];

		if (cmd.pass_start) begin
			sqs_q <= '0;
		end else if (v_s3) begin
			sqs_q <= sqs_q + smvs_pkg::SQS_W'(sq_s3);
		end

		if (cmd.mean_load) begin
			mean_q <= sum_q[smvs_pkg::SUM_W-1] ? -quo_lo : quo_lo;
		end
		if (cmd.var_load) begin
			var_q <= quotient[smvs_pkg::VAR_W-1:0];
		end
		if (cmd.out_load) begin
			res_q.mean       <= mean_q;
			res_q.variance   <= var_q;
			res_q.std_dev    <= root;
			res_q.count      <= smvs_pkg::OCNT_W'(cnt_q);
			res_q.overflowed <= drop_q;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.pass_done = pass_done_q;
	assign sts.sqrt_done = sqrt_done;
	assign res_word      = res_q;

endmodule

/* hdl/smvs_ctrl.sv */
// ----------------------------------------------------------------------------
// smvs_ctrl
// Sequencer: loads words, then steps through mean division, second pass,
// variance division and square root, and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module smvs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           smp_valid,
	input  logic           smp_last,
	input  logic           res_stall,
	input  smvs_pkg::sts_t sts,
	output logic           smp_stall,
	output logic           res_valid,
	output smvs_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_MEAN,
		ST_PASS,
		ST_VAR,
		ST_ROOT,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   go_q;
	logic   res_valid_q;
	logic   out_free;

	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		cmd            = '0;
		cmd.take       = (state_q == ST_LOAD) && smp_valid;
		cmd.div_start  = go_q && ((state_q == ST_MEAN) || (state_q == ST_VAR));
		cmd.div_var    = (state_q == ST_VAR);
		cmd.mean_load  = (state_q == ST_MEAN) && sts.div_done;
		cmd.pass_start = go_q && (state_q == ST_PASS);
		cmd.var_load   = (state_q == ST_VAR) && sts.div_done;
		cmd.sqrt_start = go_q && (state_q == ST_ROOT);
		cmd.out_load   = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			go_q        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// kick the next unit in the first cycle of ST_MEAN, ST_PASS, ST_VAR and ST_ROOT
			go_q <= ((state_q == ST_LOAD) && smp_valid && smp_last)
				|| ((state_q == ST_MEAN) && sts.div_done)
				|| ((state_q == ST_PASS) && sts.pass_done)
				|| ((state_q == ST_VAR) && sts.div_done);
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (smp_valid && smp_last) begin
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (sts.div_done) begin
						state_q <= ST_PASS;
					end
				end
				ST_PASS: begin
					if (sts.pass_done) begin
						state_q <= ST_VAR;
					end
				end
				ST_VAR: begin
					if (sts.div_done) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (sts.sqrt_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign smp_stall = (state_q != ST_LOAD);
	assign res_valid = res_valid_q;

endmodule

/* tb/smvs_stats_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smvs_stats_checker
// Watches both channels of the statistics unit. Keeps its own copy of the
// sample store, works out mean, population variance and standard deviation
// for every closed set, and compares each result word field by field with
// the oldest set still due.
// ----------------------------------------------------------------------------
module smvs_stats_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           smp_valid,
	input  logic           smp_stall,
	input  smvs_pkg::smp_t smp_word,
	input  logic           res_valid,
	input  logic           res_stall,
	input  smvs_pkg::res_t res_word,
	output int             mismatches,
	output int             awaiting
);
	import smvs_pkg::*;

	logic signed [SMP_W-1:0] kept [MAX_SAMPLES];
	int unsigned             kept_n;
	longint                  running;
	logic                    dropped;
	res_t                    stats_due [$];
	int                      fail_total = 0;

	// bit-by-bit floor square root; the root of a 48-bit value fits in 24 bits
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = SD_W; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic res_t set_statistics();
		res_t            r;
		longint          avg;
		longint          d;
		longint unsigned sq_sum;
		longint unsigned spread;
		longint unsigned root;
		// signed division truncates toward zero
		avg = running / longint'(kept_n);
		sq_sum = 0;
		for (int i = 0; i < kept_n; i++) begin
			d = longint'(kept[i]) - avg;
			sq_sum += d * d;
		end
		spread = sq_sum / kept_n;
		root = floor_root(spread);
		r.mean       = avg[SMP_W-1:0];
		r.variance   = spread[VAR_W-1:0];
		r.std_dev    = root[SD_W-1:0];
		r.count      = kept_n[OCNT_W-1:0];
		r.overflowed = dropped;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("checker: %0t ns: %s", $time, what);
		fail_total++;
	endtask

	task automatic take_sample(input smp_t w);
		if (kept_n < MAX_SAMPLES) begin
			kept[kept_n] = w.sample;
			kept_n++;
			running += $signed(w.sample);
		end else begin
			// buffer full: drop the word but remember it
			dropped = 1'b1;
		end
		if (w.last) begin
			stats_due.push_back(set_statistics());
			kept_n  = 0;
			running = 0;
			dropped = 1'b0;
		end
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (stats_due.size() == 0) begin
			report_mismatch("result word with no set closed");
			return;
		end
		want = stats_due.pop_front();
		if (got.mean !== want.mean)
			report_mismatch($sformatf("mean %0d, want %0d",
				$signed(got.mean), $signed(want.mean)));
		if (got.variance !== want.variance)
			report_mismatch($sformatf("variance %0d, want %0d",
				got.variance, want.variance));
		if (got.std_dev !== want.std_dev)
			report_mismatch($sformatf("std_dev %0d, want %0d",
				got.std_dev, want.std_dev));
		if (got.count !== want.count)
			report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
		if (got.overflowed !== want.overflowed)
			report_mismatch($sformatf("overflowed %b, want %b",
				got.overflowed, want.overflowed));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_n  = 0;
			running = 0;
			dropped = 1'b0;
			stats_due.delete();
		end else begin
			if (res_valid === 1'b1 && res_stall === 1'b0)
				check_result(res_word);
			if (smp_valid === 1'b1 && smp_stall === 1'b0)
				take_sample(smp_word);
		end
		mismatches <= fail_total;
		awaiting   <= stats_due.size();
	end

endmodule

/* tb/sample_mean_variance_stddev_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sample_mean_variance_stddev_unit_test
// Drives sets of Q12.12 sample words into the statistics unit: a few hand-
// picked sets, random sets under changing idle rates on both channels, then
// sets at and beyond the buffer depth and one long result hold-off. The
// checker beside the unit predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sample_mean_variance_stddev_unit_test;
	import smvs_pkg::*;

	localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
	localparam int HOLD_CYCLES = 1500;

	typedef enum int {WIDE, NEAR_ZERO, RAILS, CLUSTER, MIXED} spread_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic smp_valid = 1'b0;
	smp_t smp_word  = '0;
	logic res_stall = 1'b0;
	logic smp_stall;
	logic res_valid;
	res_t res_word;
	int   mismatches;
	int   awaiting;

	int   tx_idle_pct = 26;
	int   rx_idle_pct = 87;
	bit   hold_request = 1'b0;
	int   words_sent = 0;
	int   sets_sent = 0;

	sample_mean_variance_stddev_unit uut (
		.clk, .arst_n, .smp_valid, .smp_stall, .smp_word,
		.res_valid, .res_stall, .res_word
	);

	smvs_stats_checker stats_check (
		.clk, .arst_n, .smp_valid, .smp_stall, .smp_word,
		.res_valid, .res_stall, .res_word, .mismatches, .awaiting
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("tb: failure");
		$finish;
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++) begin
					res_stall <= 1'b1;
					@(posedge clk);
				end
			end
			res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	function automatic logic signed [SMP_W-1:0] draw_sample(input spread_t kind,
			input logic signed [SMP_W-1:0] centre);
		if (kind == MIXED)
			kind = spread_t'($urandom_range(0, 3));
		case (kind)
			WIDE:      return SMP_W'($urandom);
			NEAR_ZERO: return SMP_W'(int'($urandom_range(0, 128)) - 64);
			RAILS:     return $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
			default:   return centre + SMP_W'(int'($urandom_range(0, 32)) - 16);
		endcase
	endfunction

	// valid stays high from one word to the next unless an idle cycle is drawn
	task automatic offer_word(input logic signed [SMP_W-1:0] s, input logic l);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			smp_valid <= 1'b0;
			@(posedge clk);
		end
		smp_valid <= 1'b1;
		smp_word  <= '{sample: s, last: l};
		@(posedge clk);
		while (smp_stall !== 1'b0)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic offer_set(input int n);
		spread_t                 kind;
		logic signed [SMP_W-1:0] centre;
		kind   = spread_t'($urandom_range(0, 4));
		centre = SMP_W'($urandom);
		for (int i = 1; i <= n; i++)
			offer_word(draw_sample(kind, centre), i == n);
		sets_sent++;
	endtask

	// mostly short sets, now and then a longer one
	function automatic int pick_set_size();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return $urandom_range(41, 64);
		if (r < 4)
			return $urandom_range(11, 40);
		return $urandom_range(1, 10);
	endfunction

	task automatic random_phase(input int tx, input int rx, input int min_words,
			input int min_sets);
		int first_word;
		int first_set;
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		first_word  = words_sent;
		first_set   = sets_sent;
		while (words_sent - first_word < min_words || sets_sent - first_set < min_sets)
			offer_set(pick_set_size());
	endtask

	task automatic drain();
		smp_valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// single words at both rails
		offer_word(SMP_MAX, 1'b1);
		offer_word(SMP_MIN, 1'b1);
		// widest spread, mean truncates to zero
		offer_word(SMP_MIN, 1'b0);
		offer_word(SMP_MAX, 1'b1);
		// negative mean truncated toward zero, not floored
		offer_word(-24'sd1, 1'b0);
		offer_word(-24'sd1, 1'b0);
		offer_word(24'sd0, 1'b1);
		offer_word(24'sd0, 1'b0);
		offer_word(24'sd0, 1'b1);
		offer_word(24'sh555555, 1'b0);
		offer_word(24'shAAAAAA, 1'b1);
		offer_word(-24'sd5, 1'b0);
		offer_word(-24'sd6, 1'b1);
		offer_word(SMP_MAX, 1'b0);
		offer_word(SMP_MAX, 1'b0);
		offer_word(SMP_MAX, 1'b0);
		offer_word(SMP_MIN, 1'b1);

		random_phase(26, 87, 30, 3);

		// hold the sender until every result is out
		drain();
		random_phase(87, 26, 30, 3);

		random_phase(0, 0, 30, 3);
		// exactly full, then several dropped words including the closing one
		offer_set(MAX_SAMPLES);
		offer_set(MAX_SAMPLES + 4);

		// hold results off long enough for the unit to fill and stall input
		hold_request = 1'b1;
		repeat (3) offer_set($urandom_range(4, 12));

		drain();
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
